/* sv/dvde_pkg.sv */
// Shared types, constants and helper functions of the display value digit encoder.
package dvde_pkg;

  localparam int SAMPLE_W      = 48;
  localparam int THR_W         = 21;
  localparam int BCNT_W        = 4;
  localparam int MAX_BYTES_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_USE_BCD    = 2'd0;
  localparam logic [1:0] REG_BYTE_COUNT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_UNCHANGED = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_VALID     = 2'd2;

  // Sign markers
  localparam logic [7:0] BCD_NEG_MARK = 8'hFE;
  localparam logic [7:0] BIN_NEG_MARK = 8'h80;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic       last;
  } out_item_t;

  // Sample tracker control and status
  typedef struct packed {
    logic store;
    logic clear;
  } trk_ctrl_t;

  typedef struct packed {
    logic changed;
    logic busy;
  } trk_stat_t;

  // Serial converter control and status
  typedef struct packed {
    logic start;
  } dab_ctrl_t;

  typedef struct packed {
    logic busy;
  } dab_stat_t;

  // 10^n for n up to 8, zero-extended to 64 bits
  function automatic logic [63:0] pow10(input logic [BCNT_W-1:0] n);
    logic [63:0] p;
    case (n)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      default: p = 64'd100000000;
    endcase
    return p;
  endfunction

  // Mask of the low 8*n bits; eight or more bytes cover everything
  function automatic logic [63:0] bin_mask(input logic [BCNT_W-1:0] n);
    logic [63:0] m;
    case (n)
      4'd0:    m = 64'h0;
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd3:    m = 64'h0000_0000_00FF_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
      4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
      4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* sv/dvde_track.sv */
// Sample tracker: stored value and sticky change flag with threshold check.
module dvde_track (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dvde_pkg::trk_ctrl_t                  ctrl,
  input  logic signed [dvde_pkg::SAMPLE_W-1:0] sample,
  input  logic [dvde_pkg::THR_W-1:0]           threshold,
  output dvde_pkg::trk_stat_t                  stat,
  output logic signed [dvde_pkg::SAMPLE_W-1:0] last_value
);

  localparam int DIFF_W = dvde_pkg::SAMPLE_W + 1;

  logic signed [dvde_pkg::SAMPLE_W-1:0] last_r, last_nxt;
  logic        [DIFF_W-1:0]             diff_r, diff_nxt;
  logic                                 pend_r, pend_nxt;
  logic                                 changed_r, changed_nxt;
  logic        [DIFF_W-1:0]             abs_diff;

  // Difference is registered; its magnitude is checked in the following cycle
  always_comb begin
    abs_diff    = diff_r[DIFF_W-1] ? (~diff_r + 1'b1) : diff_r;
    last_nxt    = last_r;
    diff_nxt    = diff_r;
    pend_nxt    = 1'b0;
    changed_nxt = changed_r;
    if (pend_r && (abs_diff >= DIFF_W'(threshold))) begin
      changed_nxt = 1'b1;
    end
    if (ctrl.clear) begin
      changed_nxt = 1'b0;
    end
    if (ctrl.store) begin
      diff_nxt = {sample[dvde_pkg::SAMPLE_W-1], sample} - {last_r[dvde_pkg::SAMPLE_W-1], last_r};
      last_nxt = sample;
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      pend_r    <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      last_r    <= last_nxt;
      pend_r    <= pend_nxt;
      changed_r <= changed_nxt;
    end
    diff_r <= diff_nxt;
  end

  assign stat.changed = changed_r;
  assign stat.busy    = pend_r;
  assign last_value   = last_r;

  // A store never lands while the previous difference is still pending
  a_no_store_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !ctrl.store)
    else $error("store while difference check pending");

endmodule

/* sv/dvde_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module dvde_dabble #(
  parameter int MAG_W  = 32,
  parameter int DIGITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dvde_pkg::dab_ctrl_t   ctrl,
  input  logic [MAG_W-1:0]      mag,
  output dvde_pkg::dab_stat_t   stat,
  output logic [DIGITS*4-1:0]   bcd
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]    sh_r, sh_nxt;
  logic [DIGITS*4-1:0] bcd_r, bcd_nxt;
  logic [DIGITS*4-1:0] adj;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? (bcd_r[d*4 +: 4] + 4'd3) : bcd_r[d*4 +: 4];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.start) begin
      sh_nxt   = mag;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt  = {adj[DIGITS*4-2:0], sh_r[MAG_W-1]};
      sh_nxt   = sh_r << 1;
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign bcd       = bcd_r;

  // Bit count runs only while converting
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("bit counter nonzero while idle");

endmodule

/* sv/display_value_digit_encoder.sv */
// Top level: control sequencer, configuration registers and result output register.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | dvde_pkg::in_item_t (operation, sample)
//   out     | output    | out_valid/out_stall | dvde_pkg::out_item_t (status, byte_value,
//           |           |                   |   byte_index, last)
//   cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// A store computes the difference, then the threshold compare. An unchanged read emits one
// status result; a binary read takes the magnitude, checks the range and emits n bytes; a
// decimal read also runs the bit-serial shift-and-add-3 converter over 48 - FRAC_BITS bits.
// One item is in work at a time; in_stall is high until it is finished.
// Reset is synchronous on rst_n; a stall on out holds the result register and the sequencer.
module display_value_digit_encoder #(
  parameter int MAX_BYTES = dvde_pkg::MAX_BYTES_DEF,
  parameter int FRAC_BITS = dvde_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dvde_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dvde_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [dvde_pkg::THR_W-1:0]   cfg_data
);

  localparam int MAG_W = dvde_pkg::SAMPLE_W - FRAC_BITS;
  localparam int EBW   = MAX_BYTES * 8;
  localparam int BCW   = MAX_BYTES * 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MAG  = 3'd2;
  localparam logic [2:0] S_RNG  = 3'd3;
  localparam logic [2:0] S_DAB  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic                         use_bcd_r, use_bcd_nxt;
  logic [dvde_pkg::BCNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [dvde_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic [MAG_W-1:0]             mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic [dvde_pkg::BCNT_W-1:0]  n_r, n_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [2:0]                   idx_r, idx_nxt;
  logic [EBW-1:0]               ebuf_r, ebuf_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dvde_pkg::out_item_t          out_item_r, out_item_nxt;

  dvde_pkg::trk_ctrl_t          trk_ctrl;
  dvde_pkg::trk_stat_t          trk_stat;
  dvde_pkg::dab_ctrl_t          dab_ctrl;
  dvde_pkg::dab_stat_t          dab_stat;
  logic signed [dvde_pkg::SAMPLE_W-1:0] last_value;
  logic [BCW-1:0]               bcd;

  logic                         in_acc;
  logic                         slot_free;
  logic [dvde_pkg::SAMPLE_W-1:0] abs_val;
  logic [MAG_W-1:0]             mag_cur;
  logic [63:0]                  mag_wide;
  logic                         over;
  logic [2:0]                   dpos;
  logic                         is_last;
  logic [7:0]                   byte_val;

  dvde_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (trk_ctrl),
    .sample     (in_item.sample),
    .threshold  (thr_r),
    .stat       (trk_stat),
    .last_value (last_value)
  );

  dvde_dabble #(
    .MAG_W  (MAG_W),
    .DIGITS (MAX_BYTES)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dab_ctrl),
    .mag   (mag_r),
    .stat  (dab_stat),
    .bcd   (bcd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Truncated magnitude of the stored value
  assign abs_val = last_value[dvde_pkg::SAMPLE_W-1] ? (~last_value + 1'b1) : last_value;
  assign mag_cur = abs_val[dvde_pkg::SAMPLE_W-1:FRAC_BITS];

  // Range check against 10^n or 2^(8n)
  assign mag_wide = 64'(mag_r);
  assign over = use_bcd_r ? (mag_wide >= dvde_pkg::pow10(n_r))
                          : (|(mag_wide & ~dvde_pkg::bin_mask(n_r)));

  // Byte selection for the current position
  assign dpos    = 3'(n_r - 4'd1 - {1'b0, idx_r});
  assign is_last = ({1'b0, idx_r} == (n_r - 4'd1));
  always_comb begin
    if (use_bcd_r) begin
      byte_val = {4'b0000, bcd[dpos*4 +: 4]};
      if (idx_r == 3'd0 && neg_r) begin
        byte_val = dvde_pkg::BCD_NEG_MARK;
      end
    end else begin
      byte_val = ebuf_r[7:0];
      if (is_last && neg_r) begin
        byte_val = byte_val | dvde_pkg::BIN_NEG_MARK;
      end
    end
  end

  // Configuration writes
  always_comb begin
    use_bcd_nxt    = use_bcd_r;
    byte_count_nxt = byte_count_r;
    thr_nxt        = thr_r;
    if (cfg_we) begin
      case (cfg_index)
        dvde_pkg::REG_USE_BCD:    use_bcd_nxt    = cfg_data[0];
        dvde_pkg::REG_BYTE_COUNT: byte_count_nxt = cfg_data[dvde_pkg::BCNT_W-1:0];
        dvde_pkg::REG_THRESHOLD:  thr_nxt        = cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    ebuf_nxt      = ebuf_r;
    trk_ctrl      = '0;
    dab_ctrl      = '0;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_item.operation) begin
            trk_ctrl.store = 1'b1;
            state_nxt      = S_CHK;
          end else if (!trk_stat.changed) begin
            kind_nxt  = dvde_pkg::ST_UNCHANGED;
            state_nxt = S_EMIT;
          end else begin
            trk_ctrl.clear = 1'b1;
            state_nxt      = S_MAG;
          end
        end
      end
      S_CHK: begin
        state_nxt = S_IDLE;
      end
      S_MAG: begin
        mag_nxt = mag_cur;
        neg_nxt = last_value[dvde_pkg::SAMPLE_W-1] && (mag_cur != '0);
        if (byte_count_r == '0) begin
          n_nxt = dvde_pkg::BCNT_W'(1);
        end else if (byte_count_r > dvde_pkg::BCNT_W'(MAX_BYTES)) begin
          n_nxt = dvde_pkg::BCNT_W'(MAX_BYTES);
        end else begin
          n_nxt = byte_count_r;
        end
        state_nxt = S_RNG;
      end
      S_RNG: begin
        idx_nxt = '0;
        if (over) begin
          kind_nxt  = dvde_pkg::ST_RANGE;
          state_nxt = S_EMIT;
        end else if (use_bcd_r) begin
          kind_nxt       = dvde_pkg::ST_VALID;
          dab_ctrl.start = 1'b1;
          state_nxt      = S_DAB;
        end else begin
          kind_nxt  = dvde_pkg::ST_VALID;
          ebuf_nxt  = EBW'(mag_r);
          state_nxt = S_EMIT;
        end
      end
      S_DAB: begin
        if (!dab_stat.busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (kind_r != dvde_pkg::ST_VALID) begin
            out_item_nxt.status     = kind_r;
            out_item_nxt.byte_value = '0;
            out_item_nxt.byte_index = '0;
            out_item_nxt.last       = 1'b1;
            state_nxt               = S_IDLE;
          end else begin
            out_item_nxt.status     = dvde_pkg::ST_VALID;
            out_item_nxt.byte_value = byte_val;
            out_item_nxt.byte_index = idx_r;
            out_item_nxt.last       = is_last;
            idx_nxt                 = idx_r + 3'd1;
            ebuf_nxt                = ebuf_r >> 8;
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      use_bcd_r    <= 1'b1;
      byte_count_r <= dvde_pkg::BCNT_W'(4);
      thr_r        <= dvde_pkg::THR_W'(66);
      out_valid_r  <= 1'b0;
      kind_r       <= dvde_pkg::ST_UNCHANGED;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      use_bcd_r    <= use_bcd_nxt;
      byte_count_r <= byte_count_nxt;
      thr_r        <= thr_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      idx_r        <= idx_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    n_r        <= n_nxt;
    ebuf_r     <= ebuf_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Single-result reads always close the read
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != dvde_pkg::ST_VALID) |-> out_item_r.last)
    else $error("status result without last");

  // Emission position stays within the byte count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (kind_r == dvde_pkg::ST_VALID) |-> ({1'b0, idx_r} < n_r))
    else $error("byte position beyond byte count");

  // Converter only runs while the sequencer waits on it
  a_dab_owner: assert property (@(posedge clk) disable iff (!rst_n)
    dab_stat.busy |-> (state_r == S_DAB))
    else $error("converter busy outside conversion wait");

  // Tracker compare finishes while the sequencer holds the input
  a_trk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    trk_stat.busy |-> (state_r == S_CHK))
    else $error("tracker busy outside store check");

endmodule

/* tb/sv/tb_display_value_digit_encoder.sv */
// Self-checking testbench of the display value digit encoder with a built-in predictor.
module tb_display_value_digit_encoder;

  localparam logic   OP_STORE      = 1'b0;
  localparam logic   OP_READ       = 1'b1;
  localparam int     FRAC          = 16;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     HOLD_CYCLES   = 400;
  localparam longint SAMPLE_MAX    = 64'sd140737488355327;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  dvde_pkg::in_item_t         in_item   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  dvde_pkg::out_item_t        out_item;
  logic                       cfg_we    = 1'b0;
  logic [1:0]                 cfg_index = dvde_pkg::REG_USE_BCD;
  logic [dvde_pkg::THR_W-1:0] cfg_data  = '0;

  // Shadow copy of the registers and of the tracked sample
  logic                        cfg_bcd        = 1'b1;
  logic [dvde_pkg::BCNT_W-1:0] cfg_count      = 4'd4;
  logic [dvde_pkg::THR_W-1:0]  cfg_thr        = 21'd66;
  longint                      shadow_value   = 0;
  bit                          shadow_changed = 1'b0;

  dvde_pkg::in_item_t  queued_items[$];
  dvde_pkg::out_item_t awaited_bytes[$];
  dvde_pkg::out_item_t want;
  longint    gen_last      = 0;
  int        items_queued  = 0;
  int        items_taken   = 0;
  int        send_idle_pct = 18;
  int        recv_idle_pct = 64;
  int        hold_requests = 0;
  int        hold_served   = 0;
  int        hold_left     = 0;
  int        errors        = 0;
  int        n_stores      = 0;
  int        n_reads       = 0;
  int        n_valid       = 0;
  int        n_unchanged   = 0;
  int        n_range       = 0;

  display_value_digit_encoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void await_byte(input logic [1:0] st, input logic [7:0] val,
                                     input int idx, input bit lst);
    dvde_pkg::out_item_t r;
    r.status     = st;
    r.byte_value = val;
    r.byte_index = 3'(idx);
    r.last       = lst;
    awaited_bytes.push_back(r);
  endfunction

  // Predicts the digits or bytes that one accepted item produces
  function automatic void encode_item(input dvde_pkg::in_item_t it);
    longint     s, d, ad, mag, p10, tmp;
    int         n, i;
    bit         neg;
    logic [7:0] b;
    logic [7:0] digits [8];
    if (it.operation == OP_STORE) begin
      s  = {{16{it.sample[dvde_pkg::SAMPLE_W-1]}}, it.sample};
      d  = s - shadow_value;
      ad = (d < 0) ? -d : d;
      if (ad >= longint'(cfg_thr)) shadow_changed = 1'b1;
      shadow_value = s;
      return;
    end
    if (!shadow_changed) begin
      await_byte(dvde_pkg::ST_UNCHANGED, 8'd0, 0, 1'b1);
      return;
    end
    shadow_changed = 1'b0;
    n   = (cfg_count == 0) ? 1 : (cfg_count > 8) ? 8 : int'(cfg_count);
    mag = ((shadow_value < 0) ? -shadow_value : shadow_value) >> FRAC;
    neg = (shadow_value < 0) && (mag != 0);
    if (cfg_bcd) begin
      p10 = 1;
      for (i = 0; i < n; i++) p10 = p10 * 10;
      if (mag >= p10) begin
        await_byte(dvde_pkg::ST_RANGE, 8'd0, 0, 1'b1);
        return;
      end
      tmp = mag;
      for (i = n - 1; i >= 0; i--) begin
        digits[i] = 8'(tmp % 10);
        tmp = tmp / 10;
      end
      // a negative value shows the minus marker in the leading digit
      if (neg) digits[0] = dvde_pkg::BCD_NEG_MARK;
      for (i = 0; i < n; i++) await_byte(dvde_pkg::ST_VALID, digits[i], i, i == n - 1);
    end else begin
      if (n < 8 && mag >= (longint'(1) << (8 * n))) begin
        await_byte(dvde_pkg::ST_RANGE, 8'd0, 0, 1'b1);
        return;
      end
      for (i = 0; i < n; i++) begin
        b = 8'(mag >> (8 * i));
        if (i == n - 1 && neg) b = b | dvde_pkg::BIN_NEG_MARK;
        await_byte(dvde_pkg::ST_VALID, b, i, i == n - 1);
      end
    end
  endfunction

  // Random sample: full range, range edges, threshold edges, repeats and fractions
  function automatic longint pick_sample();
    longint     v, p, bound;
    int         kind, k, i;
    bit         signable;
    logic [63:0] raw;
    kind     = $urandom_range(0, 9);
    signable = 1'b1;
    case (kind)
      0: begin
        raw      = {$urandom(), $urandom()};
        v        = {{16{raw[47]}}, raw[47:0]};
        signable = 1'b0;
      end
      1, 2: begin
        k = $urandom_range(1, 8);
        p = 1;
        for (i = 0; i < k; i++) p = p * 10;
        v = longint'($urandom_range(0, 32'(p))) * 65536 + $urandom_range(0, 65535);
      end
      3: begin
        k = $urandom_range(1, 8);
        p = 1;
        for (i = 0; i < k; i++) p = p * 10;
        if ($urandom_range(0, 1)) bound = p;
        else bound = (k >= 4) ? 64'sh7FFF_FFFF : (longint'(1) << (8 * k));
        v = (bound - $urandom_range(0, 1)) * 65536 + $urandom_range(0, 65535);
      end
      4, 5: begin
        p = longint'(cfg_thr) + $urandom_range(0, 2) - 1;
        v = $urandom_range(0, 1) ? gen_last + p : gen_last - p;
        signable = 1'b0;
      end
      6: begin
        v        = gen_last;
        signable = 1'b0;
      end
      7: v = $urandom_range(0, 65535);
      default: v = longint'($urandom_range(0, 99999)) * 65536 + $urandom_range(0, 65535);
    endcase
    if (signable && $urandom_range(0, 1)) v = -v;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < -SAMPLE_MAX) v = -SAMPLE_MAX;
    return v;
  endfunction

  task automatic push_store(input longint v);
    dvde_pkg::in_item_t it;
    it.operation = OP_STORE;
    it.sample    = v[dvde_pkg::SAMPLE_W-1:0];
    queued_items.push_back(it);
    items_queued++;
    gen_last = v;
  endtask

  task automatic push_read();
    dvde_pkg::in_item_t it;
    it.operation = OP_READ;
    it.sample    = 48'({$urandom(), $urandom()});
    queued_items.push_back(it);
    items_queued++;
  endtask

  // Mostly store-then-read sequences, with lone reads and lone stores mixed in
  task automatic push_random(input int count);
    int made, p, k;
    made = 0;
    while (made < count) begin
      p = $urandom_range(0, 9);
      if (p <= 5) begin
        k = $urandom_range(1, 3);
        repeat (k) push_store(pick_sample());
        push_read();
        made += k + 1;
        if ($urandom_range(0, 3) == 0) begin
          push_read();
          made++;
        end
      end else if (p == 6) begin
        push_read();
        made++;
      end else if (p == 7) begin
        push_store(pick_sample());
        made++;
      end else begin
        push_store(pick_sample());
        push_read();
        made += 2;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [dvde_pkg::THR_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dvde_pkg::REG_USE_BCD:    cfg_bcd   = data[0];
      dvde_pkg::REG_BYTE_COUNT: cfg_count = data[dvde_pkg::BCNT_W-1:0];
      default:                  cfg_thr   = data;
    endcase
  endtask

  task automatic configure(input bit bcd, input int cnt, input int thr);
    write_reg(dvde_pkg::REG_USE_BCD, dvde_pkg::THR_W'(bcd));
    write_reg(dvde_pkg::REG_BYTE_COUNT, dvde_pkg::THR_W'(cnt));
    write_reg(dvde_pkg::REG_THRESHOLD, dvde_pkg::THR_W'(thr));
  endtask

  // Every queued item taken and every predicted result seen
  task automatic wait_idle();
    while (items_taken != items_queued || awaited_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_item(in_item);
        items_taken++;
        if (in_item.operation == OP_STORE) n_stores++;
        else n_reads++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= queued_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_bytes.size() == 0) begin
        $error("unexpected result: status %0d byte_value %0h byte_index %0d last %0d",
               out_item.status, out_item.byte_value, out_item.byte_index, out_item.last);
        errors++;
      end else begin
        want = awaited_bytes.pop_front();
        case (want.status)
          dvde_pkg::ST_UNCHANGED: n_unchanged++;
          dvde_pkg::ST_RANGE:     n_range++;
          default:                n_valid++;
        endcase
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          errors++;
        end
        if (out_item.byte_value !== want.byte_value) begin
          $error("byte_value: expected %0h, got %0h", want.byte_value, out_item.byte_value);
          errors++;
        end
        if (out_item.byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, out_item.byte_index);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          errors++;
        end
      end
    end
    // long hold-off on request, otherwise random stall
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // decimal mode at reset settings
    push_read();                          // flag clear after reset
    push_store(0);
    push_read();                          // no change from the reset value
    push_store(66);
    push_read();                          // difference equal to threshold, zero digits
    push_store(64'sd9999 * 65536 + 65535);
    push_read();                          // largest four-digit value
    push_store(64'sd10000 * 65536);
    push_read();                          // just out of range
    push_store(-(64'sd1234 * 65536 + 5));
    push_read();                          // negative, minus marker
    push_store(-32768);
    push_read();                          // minus one half truncates to plain zero
    push_store(SAMPLE_MAX);
    push_read();
    push_store(-SAMPLE_MAX);
    push_read();
    push_store(-SAMPLE_MAX);
    push_read();                          // repeat value leaves the flag clear
    drain();

    // binary mode, eight bytes, zero threshold
    configure(1'b0, 8, 0);
    push_store(SAMPLE_MAX);
    push_read();
    push_store(-SAMPLE_MAX);
    push_read();                          // sign bit in the top byte
    push_store(-SAMPLE_MAX);
    push_read();                          // zero threshold: a repeat still counts
    drain();

    // sender idles a little, receiver a lot
    configure(1'b1, 8, 0);
    hold_requests++;
    push_random(80);
    drain();
    configure(1'b0, 1, 1048576);
    push_random(80);
    drain();

    // sender idles a lot, receiver a little
    send_idle_pct = 64;
    recv_idle_pct = 18;
    configure(1'b1, 1, 1);
    push_random(40);
    wait_idle();
    push_random(40);
    drain();
    configure(1'b0, 0, 1000);
    push_random(80);
    drain();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b1, 15, 66);
    hold_requests++;
    push_random(80);
    drain();
    configure(1'b0, $urandom_range(2, 7), $urandom_range(0, 1048576));
    push_random(40);
    drain();
    configure(1'b1, $urandom_range(1, 8), $urandom_range(0, 4096));
    push_random(40);
    drain();

    $display("Covered %0d stores and %0d reads in decimal and binary modes, byte counts 0..15.",
             n_stores, n_reads);
    $display("Checked %0d digit/byte results, %0d unchanged reads, %0d out-of-range reads.",
             n_valid, n_unchanged, n_range);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
